// File: sv/idpb_pkg.sv
// Package for the inverse-distance pixel blend.
// Holds the fixed field widths, internal widths and the pixel type.
// No dependencies.
package idpb_pkg;

    // Field widths fixed by the interface.
    localparam int FRAC_IN_W = 12;
    localparam int EPS_W     = 25;
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int NUM_CRN   = 4;

    // Squared distances are unsigned Q1.24.
    localparam int Q_FRAC    = 24;
    localparam int SQ_W      = Q_FRAC + 1;

    // Denominator stays below 2^26.
    localparam int D_W       = 26;

    // Weight is floor(2^RECIP_BITS / d), up to 2^RECIP_BITS.
    localparam int RECIP_BITS = 40;
    localparam int W_W        = RECIP_BITS + 1;

    // Weight total, channel products and channel sums.
    localparam int TOT_W     = W_W + 2;
    localparam int PROD_W    = W_W + CH_W;
    localparam int ACC_W     = PROD_W + 2;

    typedef logic [PIX_W-1:0] pix_t;

endpackage

// File: sv/idpb_if.sv
// Channel interfaces of the inverse-distance pixel blend: sample input,
// blended result and epsilon register write. Depends on idpb_pkg.

interface idpb_src_if;
    import idpb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FRAC_IN_W-1:0] frac_x;
    logic [FRAC_IN_W-1:0] frac_y;
    pix_t                 pixel_near_near;
    pix_t                 pixel_near_far;
    pix_t                 pixel_far_near;
    pix_t                 pixel_far_far;

    modport source (
        output valid, frac_x, frac_y,
        output pixel_near_near, pixel_near_far, pixel_far_near, pixel_far_far,
        input  ready
    );
    modport sink (
        input  valid, frac_x, frac_y,
        input  pixel_near_near, pixel_near_far, pixel_far_near, pixel_far_far,
        output ready
    );
endinterface

interface idpb_res_if;
    import idpb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] chan0;
    logic [CH_W-1:0] chan1;
    logic [CH_W-1:0] chan2;

    modport source (output valid, chan0, chan1, chan2, input ready);
    modport sink   (input valid, chan0, chan1, chan2, output ready);
endinterface

interface idpb_cfg_if;
    import idpb_pkg::*;

    logic             valid;
    logic             ready;
    logic [EPS_W-1:0] epsilon;

    modport source (output valid, epsilon, input ready);
    modport sink   (input valid, epsilon, output ready);
endinterface

// File: sv/idpb_front.sv
// Front end: squared corner distances and the four denominators.
// Two register stages. Depends on idpb_pkg.
module idpb_front #(
    parameter int FRAC_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [idpb_pkg::FRAC_IN_W-1:0] frac_x,
    input  logic [idpb_pkg::FRAC_IN_W-1:0] frac_y,
    input  idpb_pkg::pix_t             pix_in [4],
    input  logic [idpb_pkg::EPS_W-1:0] epsilon,
    output logic                       out_valid,
    output logic [idpb_pkg::D_W-1:0]   den [4],
    output idpb_pkg::pix_t             pix_out [4]
);
    import idpb_pkg::*;

    localparam int USED = (FRAC_BITS < FRAC_IN_W) ? FRAC_BITS : FRAC_IN_W;
    localparam int DW   = FRAC_BITS + 1;
    localparam int SQF  = 2 * DW;
    localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [DW-1:0]        span [4];
    logic [SQF-1:0]       sq_full [4];
    logic [SQ_W-1:0]      sq24 [4];

    logic                 vld1_reg;
    logic [SQ_W-1:0]      sq_reg [4];
    pix_t                 pix1_reg [4];

    logic                 vld2_reg;
    logic [D_W-1:0]       den_reg [4];
    logic [D_W-1:0]       den_next [4];
    pix_t                 pix2_reg [4];

    // Near and far distances along each axis, then their squares.
    // Order: x near, x far, y near, y far.
    always_comb
    begin
        fx      = FRAC_BITS'(frac_x[USED-1:0]);
        fy      = FRAC_BITS'(frac_y[USED-1:0]);
        span[0] = DW'(fx);
        span[1] = ONE - DW'(fx);
        span[2] = DW'(fy);
        span[3] = ONE - DW'(fy);
        for (int k = 0; k < 4; k++)
        begin
            sq_full[k] = SQF'(span[k]) * SQF'(span[k]);
        end
    end

    // Bring each square to Q1.24.
    if (2 * FRAC_BITS >= Q_FRAC)
    begin : g_shr
        always_comb
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq24[k] = SQ_W'(sq_full[k] >> (2 * FRAC_BITS - Q_FRAC));
            end
        end
    end
    else
    begin : g_shl
        always_comb
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq24[k] = SQ_W'(sq_full[k]) << (Q_FRAC - 2 * FRAC_BITS);
            end
        end
    end

    // Denominator per corner; zero is taken as one.
    always_comb
    begin
        logic [D_W-1:0] sum [4];
        sum[0] = D_W'(sq_reg[0]) + D_W'(sq_reg[2]) + D_W'(epsilon);
        sum[1] = D_W'(sq_reg[0]) + D_W'(sq_reg[3]) + D_W'(epsilon);
        sum[2] = D_W'(sq_reg[1]) + D_W'(sq_reg[2]) + D_W'(epsilon);
        sum[3] = D_W'(sq_reg[1]) + D_W'(sq_reg[3]) + D_W'(epsilon);
        for (int k = 0; k < 4; k++)
        begin
            den_next[k] = (sum[k] == '0) ? D_W'(1) : sum[k];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq_reg[k]   <= sq24[k];
                pix1_reg[k] <= pix_in[k];
                den_reg[k]  <= den_next[k];
                pix2_reg[k] <= pix1_reg[k];
            end
        end
    end

    assign out_valid = vld2_reg;
    assign den       = den_reg;
    assign pix_out   = pix2_reg;

endmodule

// File: sv/idpb_recip.sv
// Reciprocal pipeline: floor(2^40 / d) for four corners, one quotient bit
// per stage by restoring division. Depends on idpb_pkg.
module idpb_recip (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [idpb_pkg::D_W-1:0] den [4],
    input  idpb_pkg::pix_t           pix_in [4],
    output logic                     out_valid,
    output logic [idpb_pkg::W_W-1:0] wgt [4],
    output idpb_pkg::pix_t           pix_out [4]
);
    import idpb_pkg::*;

    localparam int RSTG = W_W;

    logic           vld_reg [RSTG];
    logic [D_W-1:0] rem_reg [RSTG][4];
    logic [W_W-1:0] quo_reg [RSTG][4];
    logic [D_W-1:0] den_reg [RSTG][4];
    pix_t           pix_reg [RSTG][4];

    for (genvar s = 0; s < RSTG; s++)
    begin : g_stg
        logic           vld_p;
        logic [D_W-1:0] rem_p [4];
        logic [W_W-1:0] quo_p [4];
        logic [D_W-1:0] den_p [4];
        pix_t           pix_p [4];
        logic [D_W-1:0] rem_next [4];
        logic [W_W-1:0] quo_next [4];

        // Previous stage, or the pipeline input for the first stage.
        if (s == 0)
        begin : g_first
            always_comb
            begin
                vld_p = in_valid;
                for (int k = 0; k < 4; k++)
                begin
                    rem_p[k] = '0;
                    quo_p[k] = '0;
                    den_p[k] = den[k];
                    pix_p[k] = pix_in[k];
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                vld_p = vld_reg[s-1];
                for (int k = 0; k < 4; k++)
                begin
                    rem_p[k] = rem_reg[s-1][k];
                    quo_p[k] = quo_reg[s-1][k];
                    den_p[k] = den_reg[s-1][k];
                    pix_p[k] = pix_reg[s-1][k];
                end
            end
        end

        // One restoring step; the dividend is a one followed by zeros.
        always_comb
        begin
            logic [D_W:0] trial;
            for (int k = 0; k < 4; k++)
            begin
                trial = {rem_p[k], (s == 0) ? 1'b1 : 1'b0};
                if (trial >= {1'b0, den_p[k]})
                begin
                    rem_next[k] = D_W'(trial - {1'b0, den_p[k]});
                    quo_next[k] = {quo_p[k][W_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = D_W'(trial);
                    quo_next[k] = {quo_p[k][W_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= vld_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    rem_reg[s][k] <= rem_next[k];
                    quo_reg[s][k] <= quo_next[k];
                    den_reg[s][k] <= den_p[k];
                    pix_reg[s][k] <= pix_p[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[RSTG-1];
    assign wgt       = quo_reg[RSTG-1];
    assign pix_out   = pix_reg[RSTG-1];

endmodule

// File: sv/idpb_blend.sv
// Weighted sums: per-channel products, weight total, then channel sums.
// Two register stages. Depends on idpb_pkg.
module idpb_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [idpb_pkg::W_W-1:0]   wgt [4],
    input  idpb_pkg::pix_t             pix_in [4],
    output logic                       out_valid,
    output logic [idpb_pkg::ACC_W-1:0] acc [3],
    output logic [idpb_pkg::TOT_W-1:0] total
);
    import idpb_pkg::*;

    logic              vld1_reg;
    logic [PROD_W-1:0] prod_reg [NUM_CH][4];
    logic [TOT_W-1:0]  tot1_reg;
    logic              vld2_reg;
    logic [ACC_W-1:0]  acc_reg [NUM_CH];
    logic [TOT_W-1:0]  tot2_reg;

    // Products of channel value and weight, and the weight total.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    prod_reg[c][k] <= PROD_W'(pix_in[k][c*CH_W +: CH_W]) * PROD_W'(wgt[k]);
                end
            end
            tot1_reg <= (TOT_W'(wgt[0]) + TOT_W'(wgt[1]))
                      + (TOT_W'(wgt[2]) + TOT_W'(wgt[3]));
        end
    end

    // Channel sums.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                acc_reg[c] <= (ACC_W'(prod_reg[c][0]) + ACC_W'(prod_reg[c][1]))
                            + (ACC_W'(prod_reg[c][2]) + ACC_W'(prod_reg[c][3]));
            end
            tot2_reg <= tot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign acc       = acc_reg;
    assign total     = tot2_reg;

endmodule

// File: sv/idpb_div.sv
// Normalizing divider: channel sum over weight total, one quotient bit per
// stage, eight stages. The weighted mean never exceeds 255.
// Depends on idpb_pkg.
module idpb_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [idpb_pkg::ACC_W-1:0] acc [3],
    input  logic [idpb_pkg::TOT_W-1:0] total,
    output logic                       out_valid,
    output logic [idpb_pkg::CH_W-1:0]  chan [3]
);
    import idpb_pkg::*;

    logic             vld_reg [CH_W];
    logic [ACC_W-1:0] rem_reg [CH_W][NUM_CH];
    logic [CH_W-1:0]  quo_reg [CH_W][NUM_CH];
    logic [TOT_W-1:0] tot_reg [CH_W];

    for (genvar s = 0; s < CH_W; s++)
    begin : g_stg
        logic             vld_p;
        logic [ACC_W-1:0] rem_p [NUM_CH];
        logic [CH_W-1:0]  quo_p [NUM_CH];
        logic [TOT_W-1:0] tot_p;
        logic [ACC_W-1:0] rem_next [NUM_CH];
        logic [CH_W-1:0]  quo_next [NUM_CH];

        if (s == 0)
        begin : g_first
            always_comb
            begin
                vld_p = in_valid;
                tot_p = total;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    rem_p[c] = acc[c];
                    quo_p[c] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                vld_p = vld_reg[s-1];
                tot_p = tot_reg[s-1];
                for (int c = 0; c < NUM_CH; c++)
                begin
                    rem_p[c] = rem_reg[s-1][c];
                    quo_p[c] = quo_reg[s-1][c];
                end
            end
        end

        // Compare against the total shifted to this quotient bit.
        always_comb
        begin
            logic [ACC_W-1:0] shifted;
            shifted = ACC_W'(tot_p) << (CH_W - 1 - s);
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (rem_p[c] >= shifted)
                begin
                    rem_next[c] = rem_p[c] - shifted;
                    quo_next[c] = quo_p[c] | (CH_W'(1) << (CH_W - 1 - s));
                end
                else
                begin
                    rem_next[c] = rem_p[c];
                    quo_next[c] = quo_p[c];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s] <= vld_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tot_reg[s] <= tot_p;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    rem_reg[s][c] <= rem_next[c];
                    quo_reg[s][c] <= quo_next[c];
                end
            end
        end
    end

    assign out_valid = vld_reg[CH_W-1];
    assign chan      = quo_reg[CH_W-1];

endmodule

// File: sv/inverse_distance_pixel_blend.sv
// Top level of the inverse-distance pixel blend.
// Depends on idpb_pkg, idpb_if, idpb_front, idpb_recip, idpb_blend, idpb_div.
//
//   Channel  Dir  Payload                                   Handshake
//   src      in   frac_x, frac_y, four 24-bit pixels        valid/ready
//   res      out  chan0, chan1, chan2                       valid/ready
//   cfg      in   epsilon (25 bits, reset 17)               valid/ready
//
// One word is taken per cycle unless the pipeline holds. Stages in order:
// two front, 41 reciprocal (one weight bit each), two blend and eight
// normalizing stages, the last of which is the output register.
// Reset clears all valid bits and sets epsilon to 17.
// The whole pipeline holds while its last stage carries an untaken word.
// cfg is always ready.
module inverse_distance_pixel_blend #(
    parameter int FRAC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    idpb_src_if.sink    src,
    idpb_res_if.source  res,
    idpb_cfg_if.sink    cfg
);
    import idpb_pkg::*;

    logic             adv;
    logic [EPS_W-1:0] eps_reg;

    pix_t             pix_src [4];
    logic             fr_valid;
    logic [D_W-1:0]   fr_den [4];
    pix_t             fr_pix [4];
    logic             rc_valid;
    logic [W_W-1:0]   rc_wgt [4];
    pix_t             rc_pix [4];
    logic             bl_valid;
    logic [ACC_W-1:0] bl_acc [3];
    logic [TOT_W-1:0] bl_total;
    logic             dv_valid;
    logic [CH_W-1:0]  dv_chan [3];

    // Pipeline moves unless the output word is waiting.
    assign adv       = !dv_valid || res.ready;
    assign src.ready = adv;

    // Epsilon register.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_W'(17);
        end
        else if (cfg.valid)
        begin
            eps_reg <= cfg.epsilon;
        end
    end

    // Corner order: near_near, near_far, far_near, far_far.
    assign pix_src[0] = src.pixel_near_near;
    assign pix_src[1] = src.pixel_near_far;
    assign pix_src[2] = src.pixel_far_near;
    assign pix_src[3] = src.pixel_far_far;

    idpb_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (src.valid),
        .frac_x    (src.frac_x),
        .frac_y    (src.frac_y),
        .pix_in    (pix_src),
        .epsilon   (eps_reg),
        .out_valid (fr_valid),
        .den       (fr_den),
        .pix_out   (fr_pix)
    );

    idpb_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .den       (fr_den),
        .pix_in    (fr_pix),
        .out_valid (rc_valid),
        .wgt       (rc_wgt),
        .pix_out   (rc_pix)
    );

    idpb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (rc_valid),
        .wgt       (rc_wgt),
        .pix_in    (rc_pix),
        .out_valid (bl_valid),
        .acc       (bl_acc),
        .total     (bl_total)
    );

    idpb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (bl_valid),
        .acc       (bl_acc),
        .total     (bl_total),
        .out_valid (dv_valid),
        .chan      (dv_chan)
    );

    assign res.valid = dv_valid;
    assign res.chan0 = dv_chan[0];
    assign res.chan1 = dv_chan[1];
    assign res.chan2 = dv_chan[2];

endmodule
